// ----- rtl/rgb_box_blur_stream_macros.svh -----
// ---------------------------------------------------------------------------
// rgb_box_blur_stream_macros: assertion macros for the box blur block
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef RGB_BOX_BLUR_STREAM_MACROS_SVH
`define RGB_BOX_BLUR_STREAM_MACROS_SVH

// condition must hold at every clock edge
`define RBB_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define RBB_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/rbb_pkg.sv -----
// ---------------------------------------------------------------------------
// rbb_pkg: shared types and constants of the RGB box blur
// Channel widths, register indexes, reciprocal constants, lane control.
// ---------------------------------------------------------------------------
package rbb_pkg;

  localparam int CH_W    = 8;
  localparam int NUM_CH  = 3;
  localparam int PIX_W   = CH_W * NUM_CH;
  localparam int HEIGHT_MAX = 4096;

  // configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS       = 2'd2;

  // floor(s/N) = (s * ceil(2^SHIFT/N)) >> SHIFT, exact for all box sums here
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_W     = 19;
  localparam logic [RECIP_W-1:0] RECIP_R1 = RECIP_W'(((2**22) + 8) / 9);
  localparam logic [RECIP_W-1:0] RECIP_R2 = RECIP_W'(((2**22) + 24) / 25);
  localparam logic [RECIP_W-1:0] RECIP_R3 = RECIP_W'(((2**22) + 48) / 49);

  typedef struct packed {
    logic       ld_col;   // load vertical column sum
    logic       ld_box;   // shift history, load box sum
    logic       ld_prod;  // load reciprocal product
    logic [1:0] rad;      // effective radius
  } lane_ctrl_t;

  typedef struct packed {
    logic        emit;
    logic [11:0] row;
    logic [9:0]  col;
    logic        done;
  } meta_t;

  function automatic logic [RECIP_W-1:0] recip_for(input logic [1:0] rad);
    logic [RECIP_W-1:0] m;
    unique case (rad)
      2'd1:    m = RECIP_R1;
      2'd2:    m = RECIP_R2;
      default: m = RECIP_R3;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/rbb_lane.sv -----
// ---------------------------------------------------------------------------
// rbb_lane: one color channel of the box blur
// Column sum, running window of column sums, box sum and reciprocal divide.
// ---------------------------------------------------------------------------
module rbb_lane #(
  parameter int MAX_RADIUS = 3
) (
  input  logic                                   clk,
  input  rbb_pkg::lane_ctrl_t                    ctrl,
  input  logic [2*MAX_RADIUS-1:0][rbb_pkg::CH_W-1:0] slot_i,
  input  logic [rbb_pkg::CH_W-1:0]               pix_i,
  output logic [rbb_pkg::CH_W-1:0]               mean_o
);
  import rbb_pkg::*;

  localparam int LINES  = 2 * MAX_RADIUS;
  localparam int SIDE   = LINES + 1;
  localparam int COL_W  = $clog2(SIDE * 255 + 1);
  localparam int BOX_W  = $clog2(SIDE * SIDE * 255 + 1);
  localparam int PROD_W = BOX_W + RECIP_W;

  logic [3:0]        lines;
  logic [COL_W-1:0]  col_nxt, col_r;
  logic [COL_W-1:0]  hist_r [SIDE-1];
  logic [BOX_W-1:0]  box_nxt, box_r;
  logic [PROD_W-1:0] prod_r;

  assign lines = {1'b0, ctrl.rad, 1'b0};

  // vertical sum: stored rows in use plus the new pixel
  always_comb begin
    col_nxt = COL_W'(pix_i);
    for (int k = 0; k < LINES; k++) begin
      if (4'(k) < lines) col_nxt = col_nxt + COL_W'(slot_i[k]);
    end
  end

  // horizontal sum over newest column and the previous 2R columns
  always_comb begin
    box_nxt = BOX_W'(col_r);
    for (int m = 0; m < SIDE - 1; m++) begin
      if (4'(m) < lines) box_nxt = box_nxt + BOX_W'(hist_r[m]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_col) col_r <= col_nxt;
    if (ctrl.ld_box) begin
      box_r     <= box_nxt;
      hist_r[0] <= col_r;
      for (int m = 1; m < SIDE - 1; m++) hist_r[m] <= hist_r[m-1];
    end
    if (ctrl.ld_prod) prod_r <= PROD_W'(box_r) * PROD_W'(recip_for(ctrl.rad));
  end

  assign mean_o = prod_r[RECIP_SHIFT +: CH_W];

endmodule

// ----- rtl/rgb_box_blur_stream.sv -----
// ---------------------------------------------------------------------------
// rgb_box_blur_stream: streaming (2R+1)x(2R+1) box mean blur of RGB pixels
// Registers: input and line store read, column sum, box sum, product, result.
// Throughput: one pixel per cycle unless a result waits; one line store word
// per column, read and written once per pixel, bypass on same-column hits.
// Reset: synchronous active-low; registers go to 1024x768, radius 1, position
// zero. Line store contents are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
`include "rgb_box_blur_stream_macros.svh"

module rgb_box_blur_stream #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_red,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_blue_mean,
  output logic [7:0]  out_green_mean,
  output logic [7:0]  out_red_mean,
  output logic [11:0] out_row,
  output logic [9:0]  out_col,
  output logic        out_frame_done
);
  import rbb_pkg::*;

  localparam int LINES  = 2 * MAX_RADIUS;
  localparam int WORD_W = LINES * PIX_W;
  localparam int CW     = $clog2(MAX_WIDTH);

  // configuration
  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [1:0]  radius_r;
  logic        cfg_hit;
  logic [12:0] w_eff, h_eff, rad13, lines13;
  logic [1:0]  rad_eff;

  // position
  logic [CW-1:0] col_r;
  logic [11:0]   row_r;
  logic [12:0]   col_ext, row_ext;

  // pipeline
  logic          en, in_xfer;
  logic          v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic [PIX_W-1:0] pix1_r;
  logic [CW-1:0] addr1_r;
  meta_t         meta_now, meta1_r, meta2_r, meta3_r, meta4_r, meta_out_r;
  logic [WORD_W-1:0] mem [MAX_WIDTH];
  logic [WORD_W-1:0] rd_r, bypd_r, word, word_nxt;
  logic          byp_r;
  logic [7:0]    mean [NUM_CH];
  logic [7:0]    mean_out_r [NUM_CH];
  lane_ctrl_t    lane_ctrl;

  // effective register values after clamping
  always_comb begin
    if (width_r == 11'd0) w_eff = 13'd1;
    else if (13'(width_r) > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
    else w_eff = 13'(width_r);
    if (height_r == 13'd0) h_eff = 13'd1;
    else if (height_r > 13'(HEIGHT_MAX)) h_eff = 13'(HEIGHT_MAX);
    else h_eff = height_r;
    if (radius_r == 2'd0) rad_eff = 2'd1;
    else if (3'(radius_r) > 3'(MAX_RADIUS)) rad_eff = 2'(MAX_RADIUS);
    else rad_eff = radius_r;
  end

  assign rad13   = 13'(rad_eff);
  assign lines13 = 13'({rad_eff, 1'b0});
  assign col_ext = 13'(col_r);
  assign row_ext = 13'(row_r);
  assign cfg_hit = cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT ||
                              cfg_index == REG_RADIUS);

  // global advance: pipeline moves unless a result waits
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign in_xfer  = in_valid && in_ready;

  // per-pixel tag: whether it completes a box, and the center position
  always_comb begin
    meta_now.emit = (row_ext >= lines13) && (col_ext >= lines13);
    meta_now.row  = 12'(row_ext - rad13);
    meta_now.col  = 10'(col_ext - rad13);
    meta_now.done = (row_ext + 13'd1 == h_eff) && (col_ext + 13'd1 == w_eff);
  end

  // configuration registers and raster position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd1024;
      height_r <= 13'd768;
      radius_r <= 2'd1;
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[10:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default:          radius_r <= cfg_wdata[1:0];
      endcase
      col_r <= '0;
      row_r <= '0;
    end else if (in_xfer) begin
      if (col_ext + 13'd1 >= w_eff) begin
        col_r <= '0;
        if (row_ext + 13'd1 >= h_eff) row_r <= '0;
        else row_r <= row_r + 12'd1;
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // line store word update: oldest row drops, new pixel enters at slot 2R-1
  assign word = byp_r ? bypd_r : rd_r;
  always_comb begin
    for (int k = 0; k < LINES; k++) begin
      if (k + 1 < 2 * int'(rad_eff)) word_nxt[k*PIX_W +: PIX_W] = word[(k+1)*PIX_W +: PIX_W];
      else if (k + 1 == 2 * int'(rad_eff)) word_nxt[k*PIX_W +: PIX_W] = pix1_r;
      else word_nxt[k*PIX_W +: PIX_W] = word[k*PIX_W +: PIX_W];
    end
  end

  // line store memory with bypass of the write from the previous transfer
  always_ff @(posedge clk) begin
    if (en) begin
      if (v1_r) mem[addr1_r] <= word_nxt;
      rd_r   <= mem[col_r];
      byp_r  <= v1_r && (addr1_r == col_r);
      bypd_r <= word_nxt;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      pix1_r     <= {in_red, in_green, in_blue};
      addr1_r    <= col_r;
      meta1_r    <= meta_now;
      meta2_r    <= meta1_r;
      meta3_r    <= meta2_r;
      meta4_r    <= meta3_r;
      meta_out_r <= meta4_r;
      for (int ch = 0; ch < NUM_CH; ch++) mean_out_r[ch] <= mean[ch];
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_xfer;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r && meta4_r.emit;
    end
  end

  // channel lanes
  assign lane_ctrl.ld_col  = en && v1_r;
  assign lane_ctrl.ld_box  = en && v2_r;
  assign lane_ctrl.ld_prod = en && v3_r;
  assign lane_ctrl.rad     = rad_eff;

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    logic [LINES-1:0][CH_W-1:0] slot;
    for (genvar k = 0; k < LINES; k++) begin : g_slot
      assign slot[k] = word[k*PIX_W + ch*CH_W +: CH_W];
    end
    rbb_lane #(.MAX_RADIUS(MAX_RADIUS)) u_lane (
      .clk    (clk),
      .ctrl   (lane_ctrl),
      .slot_i (slot),
      .pix_i  (pix1_r[ch*CH_W +: CH_W]),
      .mean_o (mean[ch])
    );
  end

  // merged result register
  assign out_valid      = out_valid_r;
  assign out_blue_mean  = mean_out_r[0];
  assign out_green_mean = mean_out_r[1];
  assign out_red_mean   = mean_out_r[2];
  assign out_row        = meta_out_r.row;
  assign out_col        = meta_out_r.col;
  assign out_frame_done = meta_out_r.done;

  // checks
  `RBB_CHECK(a_col_in_frame, col_ext < w_eff, "column position beyond frame width")
  `RBB_CHECK(a_row_in_frame, row_ext < h_eff, "row position beyond frame height")
  `RBB_IMPLIES(a_done_row, out_valid_r && out_frame_done, 13'(out_row) + rad13 + 13'd1 == h_eff, "frame end flagged off the last box row")

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the streaming RGB box blur
// Drives raster pixels through valid/ready, predicts each interior box mean
// with a bit-accurate line store and window model, and compares every result
// transfer field by field. Frame geometry and radius are changed between
// phases, including saturated, degenerate and too-small settings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rbb_pkg::*;

  // index with no register behind it
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [11:0] row;
    logic [9:0]  col;
    logic        done;
  } blur_result_t;

  // Box mean predictor plus queue of pending means
  class blur_scoreboard;
    logic [23:0]  line_mem [6][1024];
    logic [23:0]  win [7][7];
    int unsigned  width_reg, height_reg, radius_reg, row_pos, col_pos;
    blur_result_t means_q [$];
    int           errors;

    function new();
      foreach (line_mem[i, j]) line_mem[i][j] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      width_reg = 1024;
      height_reg = 768;
      radius_reg = 1;
      row_pos = 0;
      col_pos = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [12:0] val);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg = val & 13'h7FF;
        REG_IMAGE_HEIGHT: height_reg = val;
        REG_RADIUS:       radius_reg = val & 13'h3;
        default:          return;
      endcase
      row_pos = 0;
      col_pos = 0;
    endfunction

    function int pending();
      return means_q.size();
    endfunction

    // advance the window by one pixel; queue a mean for interior centers
    function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      int unsigned rad, side, nlines, w, h, c, sb, sg, sr, nbox;
      logic [23:0] vcol [7];
      logic [23:0] pix;
      blur_result_t m;
      rad = (radius_reg == 0) ? 1 : (radius_reg > 3 ? 3 : radius_reg);
      side = 2 * rad + 1;
      nlines = 2 * rad;
      w = (width_reg == 0) ? 1 : (width_reg > 1024 ? 1024 : width_reg);
      h = (height_reg == 0) ? 1 : (height_reg > 4096 ? 4096 : height_reg);
      c = (col_pos >= 1024) ? 1023 : col_pos;
      pix = {r, g, b};
      for (int k = 0; k < nlines; k++) vcol[k] = line_mem[k][c];
      vcol[nlines] = pix;
      for (int k = 0; k + 1 < nlines; k++) line_mem[k][c] = line_mem[k + 1][c];
      line_mem[nlines - 1][c] = pix;
      for (int k = 0; k < side; k++) begin
        for (int j = 0; j + 1 < side; j++) win[k][j] = win[k][j + 1];
        win[k][side - 1] = vcol[k];
      end
      if (row_pos >= nlines && c >= nlines && row_pos < h && c < w) begin
        sb = 0; sg = 0; sr = 0;
        nbox = side * side;
        for (int k = 0; k < side; k++)
          for (int j = 0; j < side; j++) begin
            sb += win[k][j][7:0];
            sg += win[k][j][15:8];
            sr += win[k][j][23:16];
          end
        m.blue = 8'(sb / nbox);
        m.green = 8'(sg / nbox);
        m.red = 8'(sr / nbox);
        m.row = 12'(row_pos - rad);
        m.col = 10'(c - rad);
        m.done = (row_pos + 1 == h && c + 1 == w);
        means_q.push_back(m);
      end
      c++;
      if (c >= w) begin
        c = 0;
        row_pos++;
        if (row_pos >= h) row_pos = 0;
      end
      col_pos = c;
    endfunction

    function void cmp(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $realtime, name, exp_v,
                 got_v);
        errors++;
      end
    endfunction

    function void check_mean(blur_result_t got);
      blur_result_t e;
      if (means_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual row %0d col %0d",
                 $realtime, got.row, got.col);
        errors++;
        return;
      end
      e = means_q.pop_front();
      cmp("blue_mean", e.blue, got.blue);
      cmp("green_mean", e.green, got.green);
      cmp("red_mean", e.red, got.red);
      cmp("out_row", e.row, got.row);
      cmp("out_col", e.col, got.col);
      cmp("frame_done", e.done, got.done);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_blue = '0, in_green = '0, in_red = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_blue_mean, out_green_mean, out_red_mean;
  logic [11:0] out_row;
  logic [9:0]  out_col;
  logic        out_frame_done;

  blur_scoreboard sb = new();
  bit quiet = 1'b0;  // no idling in the closing stretch
  int out_stall = 0;

  rgb_box_blur_stream dut (.*);

  always #1 clk = ~clk;

  // result side: check each transfer, random stall bursts on out_ready
  always @(posedge clk) begin
    blur_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.blue = out_blue_mean;
      got.green = out_green_mean;
      got.red = out_red_mean;
      got.row = out_row;
      got.col = out_col;
      got.done = out_frame_done;
      sb.check_mean(got);
    end
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [12:0] val);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned r);
    write_cfg(REG_IMAGE_WIDTH, 13'(w));
    write_cfg(REG_IMAGE_HEIGHT, 13'(h));
    write_cfg(REG_RADIUS, 13'(r));
  endtask

  // one pixel transfer, with an optional idle burst ahead of it
  task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_blue <= b;
    in_green <= g;
    in_red <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(b, g, r);
  endtask

  task automatic send_random(int unsigned count);
    logic [7:0] b, g, r;
    int unsigned sel;
    repeat (count) begin
      sel = $urandom_range(0, 7);
      b = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom);
      g = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom);
      r = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom);
      send_pixel(b, g, r);
    end
  endtask

  // let every pending mean arrive, then cover pipeline latency
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    int unsigned sent, w, h, r, n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry 1024 wide, radius 1: first row only, no results yet
    send_random(100);
    drain();

    // smallest frame: all-black then all-white then one mixed frame
    set_frame(3, 3, 1);
    repeat (9) send_pixel(8'h00, 8'h00, 8'h00);
    repeat (9) send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_random(9);
    drain();

    // largest box, exactly fitting frame
    set_frame(7, 7, 3);
    repeat (49) send_pixel(8'hFF, 8'h00, 8'hFF);
    drain();

    // radius zero behaves as radius one
    set_frame(5, 4, 0);
    send_random(20);
    drain();

    // frames too small for the box, zero width and height: no results
    set_frame(2, 9, 1);
    send_random(18);
    drain();
    set_frame(0, 0, 2);
    send_random(5);
    drain();

    // saturated width and height, unused register index must not restart
    set_frame(13'h1FFF, 13'h1FFF, 3);
    send_random(60);
    drain();
    write_cfg(REG_UNUSED, 13'h0AAA);
    send_random(60);
    drain();

    // random geometries, mostly whole frames
    sent = 0;
    while (sent < 500) begin
      r = $urandom_range(0, 3);
      if ($urandom_range(0, 5) == 0) begin
        w = $urandom_range(0, 8);
        h = $urandom_range(0, 8);
      end else begin
        w = $urandom_range(7, 16);
        h = $urandom_range(7, 10);
      end
      set_frame(w, h, r);
      if (sent > 380) quiet = 1'b1;
      if ($urandom_range(0, 3) == 0)
        n = $urandom_range(1, 60);
      else
        n = (w == 0 ? 1 : w) * (h == 0 ? 1 : h) * $urandom_range(1, 2);
      send_random(n);
      sent += n;
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end
endmodule
